### rtl/core/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int unsigned LeadMax = 7;

  localparam logic [25:0] SuppBase = 26'h001_0000;
  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase = 16'hDC00;
  localparam logic [7:0] ByteMask = 8'hFF;

  // One decoded value, already split into code units where needed
  typedef struct packed {
    logic [15:0] unit0;   // plain unit, or high surrogate
    logic [15:0] unit1;   // low surrogate
    logic pair;
    logic done;
  } u8u16_val_t;

  // Leading-one count of a lead byte, saturating at seven
  function automatic logic [2:0] lead_ones(input logic [7:0] b);
    logic [2:0] n;
    logic run;
    n = 3'd0;
    run = 1'b1;
    for (int i = 0; i < LeadMax; i++) begin
      if (run && b[7 - i]) begin
        n = n + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // Lead-byte payload: top n bits cleared
  function automatic logic [7:0] lead_payload(input logic [7:0] b, input logic [2:0] n);
    logic [7:0] mask;
    mask = ByteMask >> n;
    return b & mask;
  endfunction

endpackage

### rtl/core/u8u16_in_if.sv
`timescale 1ns / 1ps

interface u8u16_in_if;
  logic valid;
  logic ready;
  logic [7:0] byte_in;
  logic end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink (input valid, input byte_in, input end_of_string, output ready);
endinterface

### rtl/core/u8u16_out_if.sv
`timescale 1ns / 1ps

interface u8u16_out_if;
  logic valid;
  logic ready;
  logic [15:0] code_unit;
  logic last_of_run;
  logic string_done;

  modport source (output valid, output code_unit, output last_of_run,
                  output string_done, input ready);
  modport sink (input valid, input code_unit, input last_of_run,
                input string_done, output ready);
endinterface

### rtl/core/u8u16_decode.sv
`timescale 1ns / 1ps

module u8u16_decode (
  input  logic clk,
  input  logic rst_n,
  u8u16_in_if.sink in_ch,
  input  logic stage_free,
  output logic val_wr,
  output u8u16_pkg::u8u16_val_t val_data
);
  import u8u16_pkg::*;

  logic [2:0] rem_r, rem_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0] lead_n;
  logic emit;
  logic xfer;
  logic [25:0] off;

  assign in_ch.ready = stage_free;
  assign xfer = in_ch.valid && stage_free;

  // Byte decode: lead byte starts a value, following bytes shift in 6 bits
  always_comb begin
    lead_n = lead_ones(in_ch.byte_in);
    if (rem_r == 3'd0) begin
      acc_nxt = {24'd0, lead_payload(in_ch.byte_in, lead_n)};
      rem_nxt = (lead_n > 3'd1) ? (lead_n - 3'd1) : 3'd0;
    end else begin
      acc_nxt = {acc_r[25:0], in_ch.byte_in[5:0]};
      rem_nxt = rem_r - 3'd1;
    end
    emit = (rem_nxt == 3'd0) || in_ch.end_of_string;
  end

  // Surrogate split of the finished value
  always_comb begin
    off = acc_nxt[25:0] - SuppBase;
    val_data.pair = !acc_nxt[31] && (acc_nxt[30:16] != 15'd0);
    val_data.done = in_ch.end_of_string;
    if (val_data.pair) begin
      val_data.unit0 = off[25:10] + HighSurrBase;
    end else begin
      val_data.unit0 = acc_nxt[15:0];
    end
    val_data.unit1 = {6'd0, off[9:0]} + LowSurrBase;
  end

  assign val_wr = xfer && emit;

  // Character state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      acc_r <= 32'd0;
    end else if (xfer) begin
      if (emit) begin
        rem_r <= 3'd0;
        acc_r <= 32'd0;
      end else begin
        rem_r <= rem_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

endmodule

### rtl/core/u8u16_split.sv
`timescale 1ns / 1ps

module u8u16_split (
  input  logic clk,
  input  logic rst_n,
  input  logic val_wr,
  input  u8u16_pkg::u8u16_val_t val_data,
  output logic stage_free,
  u8u16_out_if.source out_ch
);
  import u8u16_pkg::*;

  logic val_valid_r;
  u8u16_val_t val_r;
  logic phase_r;
  logic last;
  logic leave;

  // A pair leaves after its second unit transfer
  assign last = !val_r.pair || phase_r;
  assign leave = val_valid_r && out_ch.ready && last;
  assign stage_free = !val_valid_r || leave;

  assign out_ch.valid = val_valid_r;
  assign out_ch.code_unit = (val_r.pair && phase_r) ? val_r.unit1 : val_r.unit0;
  assign out_ch.last_of_run = last;
  assign out_ch.string_done = val_r.done && last;

  // Control: valid and surrogate phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (val_wr) begin
      val_valid_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (leave) begin
      val_valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (val_valid_r && out_ch.ready) begin
      phase_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (val_wr) begin
      val_r <= val_data;
    end
  end

endmodule

### rtl/core/utf8_to_utf16_decoder_top.sv
// A byte that completes a character shows its first unit in the cycle after its transfer.
// Throughput: one byte per cycle while the receiver keeps up; a surrogate pair holds the result
// register for two output transfers, so the byte after it waits until the second unit is taken.
// Reset (rst_n low, synchronous): character state cleared, result register empty.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_top (
  input  logic clk,
  input  logic rst_n,
  u8u16_in_if.sink in_ch,
  u8u16_out_if.source out_ch
);
  import u8u16_pkg::*;

  logic stage_free;
  logic val_wr;
  u8u16_val_t val_data;

  u8u16_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .stage_free (stage_free),
    .val_wr     (val_wr),
    .val_data   (val_data)
  );

  u8u16_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .val_wr     (val_wr),
    .val_data   (val_data),
    .stage_free (stage_free),
    .out_ch     (out_ch)
  );

endmodule

### sim/tb_utf8_to_utf16_decoder_top.sv
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_OFF_CYCLES = 300;

  localparam logic [31:0] SUPP_BASE = 32'h0001_0000;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE = 16'hDC00;

  // One UTF-16 unit as it leaves the block
  typedef struct packed {
    logic [15:0] code_unit;
    logic last_of_run;
    logic string_done;
  } unit_t;

  logic clk;
  logic rst_n;

  u8u16_in_if in_ch ();
  u8u16_out_if out_ch ();

  utf8_to_utf16_decoder_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Decoder state mirrored by the testbench
  logic [2:0] owed_bytes;
  logic [31:0] char_value;
  unit_t expected_units[$];

  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hang guard
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d units outstanding", cycle_count,
                 expected_units.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Queue the units for one decoded value, split into a pair when supplementary
  function automatic void push_value(input logic [31:0] v, input logic eos);
    logic [31:0] off;
    unit_t u;
    if (!v[31] && v >= SUPP_BASE) begin
      off = v - SUPP_BASE;
      u.code_unit = 16'(off >> 10) + HIGH_SURR_BASE;
      u.last_of_run = 1'b0;
      u.string_done = 1'b0;
      expected_units.push_back(u);
      u.code_unit = {6'd0, off[9:0]} + LOW_SURR_BASE;
    end else begin
      u.code_unit = v[15:0];
    end
    u.last_of_run = 1'b1;
    u.string_done = eos;
    expected_units.push_back(u);
  endfunction

  // Advance the mirrored decoder by one accepted byte
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    int ones;
    logic [7:0] payload;
    if (owed_bytes == 3'd0) begin
      ones = 0;
      while (ones < 7 && b[7 - ones]) ones++;
      payload = b << ones;
      payload = payload >> ones;
      char_value = {24'd0, payload};
      owed_bytes = (ones > 1) ? 3'(ones - 1) : 3'd0;
    end else begin
      char_value = (char_value << 6) | {26'd0, b[5:0]};
      owed_bytes = owed_bytes - 3'd1;
    end
    if (owed_bytes == 3'd0 || eos) begin
      push_value(char_value, eos);
      owed_bytes = 3'd0;
      char_value = 32'd0;
    end
  endfunction

  // Offer one byte, with random idle cycles ahead of it, and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic eos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.byte_in = b;
    in_ch.end_of_string = eos;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, eos);
  endtask

  // Stop offering and let every queued unit come out
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Build one string of mostly well-formed characters with random content
  task automatic send_random_string(output int sent);
    logic [7:0] text[$];
    logic [7:0] lead;
    int nchars;
    int ones;
    int follow;
    int cut;
    nchars = $urandom_range(1, 6);
    repeat (nchars) begin
      case ($urandom_range(9))
        0, 1: ones = 0;
        2: ones = 2;
        3, 4: ones = 3;
        5, 6: ones = 4;
        7: ones = $urandom_range(5, 7);
        8: ones = -1;
        default: ones = $urandom_range(0, 7);
      endcase
      if (ones < 0) begin
        // raw noise bytes
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
      end else begin
        if (ones == 7) begin
          lead = {7'h7F, 1'($urandom)};
        end else begin
          lead = (8'hFF << (8 - ones)) | (8'($urandom) & (8'h7F >> ones));
        end
        text.push_back(lead);
        follow = (ones > 1) ? ones - 1 : 0;
        repeat (follow) begin
          // now and then a follower that is not of continuation form
          if ($urandom_range(9) == 0) begin
            text.push_back(8'($urandom));
          end else begin
            text.push_back({2'b10, 6'($urandom)});
          end
        end
      end
    end
    // string cut short, often in the middle of a character
    if ($urandom_range(9) == 0 && text.size() > 1) begin
      cut = $urandom_range(1, text.size() - 1);
      repeat (cut) void'(text.pop_back());
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    sent = text.size();
  endtask

  // Receiver: random stalls, plus a counted hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each result transfer against the oldest expected unit
  always @(posedge clk) begin
    unit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_units.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Unexpected unit %h last=%b done=%b", out_ch.code_unit,
                   out_ch.last_of_run, out_ch.string_done);
        end
      end else begin
        want = expected_units.pop_front();
        if (out_ch.code_unit !== want.code_unit || out_ch.last_of_run !== want.last_of_run ||
            out_ch.string_done !== want.string_done) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Mismatch: expected %h last=%b done=%b, got %h last=%b done=%b",
                     want.code_unit, want.last_of_run, want.string_done,
                     out_ch.code_unit, out_ch.last_of_run, out_ch.string_done);
          end
        end
      end
    end
  end

  // Field extremes and the corner cases of the decoder
  task automatic test_edge_bytes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // zero byte is ordinary data and here ends a string
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    // stray continuation byte read as a lead with one leading one
    send_byte(8'h80, 1'b0);
    // follower without continuation form still contributes its low bits
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    // largest single unit
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // smallest surrogate pair
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    // seven leading ones, accumulator wraps to a negative value
    send_byte(8'hFE, 1'b0);
    repeat (5) send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // string ends while bytes are still owed
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drained();
  endtask

  // Random strings under one idling setting
  task automatic test_random_strings(input int idle_pct, input int stall_pct, input int nbytes);
    int total;
    int sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    total = 0;
    while (total < nbytes) begin
      send_random_string(sent);
      total += sent;
    end
    wait_drained();
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    int total;
    int sent;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    total = 0;
    while (total < 150) begin
      send_random_string(sent);
      total += sent;
    end
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    owed_bytes = 3'd0;
    char_value = 32'd0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_in = 8'h00;
    in_ch.end_of_string = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_bytes();
    test_random_strings(0, 0, 500);
    test_random_strings(48, 0, 500);
    test_random_strings(0, 48, 500);
    test_random_strings(17, 17, 500);
    test_backpressure();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_in_if.sv
rtl/core/u8u16_out_if.sv
rtl/core/u8u16_decode.sv
rtl/core/u8u16_split.sv
rtl/core/utf8_to_utf16_decoder_top.sv
sim/tb_utf8_to_utf16_decoder_top.sv
